/* hdl/rsi_pkg.sv */
// Shared types and constants for the radix string to integer parser.
`default_nettype none

package rsi_pkg;

    // Parse phase of the current string.
    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_STOP
    } phase_t;

    // Per-string parse state.
    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic [31:0] accum;
    } parse_state_t;

    // Outcome of one character step.
    typedef struct packed {
        logic         is_nul;
        logic [31:0]  result;
        parse_state_t next_state;
    } step_out_t;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] MIN_BASE    = 6'd2;
    localparam logic [5:0] MAX_BASE    = 6'd36;

    // Register map: byte address bit 2 selects the register index.
    localparam int         PADDR_W    = 3;
    localparam logic       REG_RADIX  = 1'b0;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

    localparam parse_state_t STATE_RESET = '{phase: PH_SPACE, negative: 1'b0, accum: 32'd0};

endpackage

`default_nettype wire

/* hdl/rsi_step.sv */
// Combinational next-state and result logic for one character of the string.
`default_nettype none

module rsi_step (
    input  wire logic [7:0]          char_code,
    input  wire logic [5:0]          radix,
    input  rsi_pkg::parse_state_t    state,
    output rsi_pkg::step_out_t       step
);
    import rsi_pkg::*;

    logic        digit_ok;
    logic [5:0]  digit_val;
    logic [31:0] product;

    // Map the character to a digit value and check it against the base.
    always_comb begin
        digit_val = 6'd63;
        if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
            digit_val = 6'(char_code - CHAR_ZERO);
        end else if (char_code >= CHAR_UP_A && char_code <= CHAR_UP_Z) begin
            digit_val = 6'(char_code - CHAR_UP_A) + 6'd10;
        end else if (char_code >= CHAR_LO_A && char_code <= CHAR_LO_Z) begin
            digit_val = 6'(char_code - CHAR_LO_A) + 6'd10;
        end
        digit_ok = (radix >= MIN_BASE) && (radix <= MAX_BASE) && (digit_val < radix);
    end

    // One multiply-add on the accumulator, wrapped to 32 bits.
    assign product = state.accum * {26'd0, radix};

    // Walk the phases in order within a single character, as the parser does.
    always_comb begin
        parse_state_t ns;
        logic         done;
        ns   = state;
        done = 1'b0;
        step.is_nul = (char_code == CHAR_NUL);
        step.result = state.negative ? (32'd0 - state.accum) : state.accum;
        if (radix < MIN_BASE) begin
            step.result = '1;
        end
        if (step.is_nul) begin
            ns = STATE_RESET;
        end else begin
            if (ns.phase == PH_SPACE) begin
                if (char_code == CHAR_SPACE || char_code == CHAR_TAB) begin
                    done = 1'b1;
                end else begin
                    ns.phase = PH_SIGN;
                end
            end
            if (!done && ns.phase == PH_SIGN) begin
                if (char_code == CHAR_PLUS || char_code == CHAR_MINUS) begin
                    ns.negative = ns.negative ^ (char_code == CHAR_MINUS);
                    done = 1'b1;
                end else begin
                    ns.phase = PH_DIGIT;
                end
            end
            if (!done && ns.phase == PH_DIGIT) begin
                if (digit_ok) begin
                    ns.accum = product + {26'd0, digit_val};
                end else begin
                    ns.phase = PH_STOP;
                end
            end
        end
        step.next_state = ns;
    end

endmodule

`default_nettype wire

/* hdl/radix_string_to_integer.sv */
// Top level of the ASCII radix string to signed integer parser.
`default_nettype none

// Takes one ASCII byte per transfer and parses a signed integer in the base held
// in the radix register (byte address 0, 6 bits, reset 10). Leading spaces and tabs
// are skipped, any run of '+' and '-' sets the sign, and digits below the base are
// accumulated modulo 2^32. A zero byte ends the string and produces one result
// transfer; all other bytes produce none. A base below 2 gives -1, a base above 36
// gives 0. One byte is accepted every cycle: each byte is held in the input
// register and is then folded into the parse state by a single 32x6 multiply-add.
// At that same edge a zero byte's result is written to the output register, so
// m_valid rises as the zero byte leaves the input register. The input stalls only
// when a zero byte finds the output register still full.
module radix_string_to_integer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Byte input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_char_code,
    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [31:0]                 m_value,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rsi_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import rsi_pkg::*;

    logic [5:0]   radix_reg;
    logic [7:0]   char_reg;
    logic         in_valid_reg;
    parse_state_t state_reg;
    logic         m_valid_reg;
    logic [31:0]  value_reg;

    step_out_t    step;
    logic         out_free;
    logic         consume;
    logic         emit;

    // Configuration register, written on the access cycle of a write.
    assign pready = 1'b1;
    assign prdata = {26'd0, radix_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_RADIX) begin
            radix_reg <= pwdata[5:0];
        end
    end

    // Per-character parse step.
    rsi_step u_step (
        .char_code (char_reg),
        .radix     (radix_reg),
        .state     (state_reg),
        .step      (step)
    );

    // The held byte moves on unless it ends a string and the result slot is full.
    assign out_free = !m_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!step.is_nul || out_free);
    assign emit     = consume && step.is_nul;
    assign s_ready  = !in_valid_reg || consume;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg <= s_char_code;
        end
    end

    // Parse state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (consume) begin
            state_reg <= step.next_state;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            value_reg <= step.result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = value_reg;

    // A string end returns the parse state to its reset values.
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (state_reg == STATE_RESET))
        else $error("parse state not cleared after string end");

    // A base below 2 always reports minus one.
    a_low_base_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && radix_reg < MIN_BASE) |=> (m_valid && value_reg == 32'hFFFF_FFFF))
        else $error("base below 2 did not yield minus one");

    // Once stopped, only a string end leaves the stopped phase.
    a_stop_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && !step.is_nul && state_reg.phase == PH_STOP)
            |=> (state_reg.phase == PH_STOP))
        else $error("parser left the stopped phase early");

    // A stalled byte stays in the input register.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(char_reg)))
        else $error("stalled input byte was lost");

    // A non-terminating byte never produces a result.
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !emit) |=> !m_valid_reg)
        else $error("result appeared without a string end");

endmodule

`default_nettype wire
